// ===== src/toiir_pkg.sv =====
package toiir_pkg;

    localparam int SAMPLE_W         = 24;
    localparam int COEF_W           = 28;
    localparam int FRAC_W           = 24;
    localparam int CH_FIELD_W       = 3;
    localparam int NUM_COEFS        = 7;
    localparam int DEFAULT_CHANNELS = 8;

    // Product of one coefficient and one sample, and the accumulator with headroom
    // for seven such terms plus the rounding constant.
    localparam int PROD_W = COEF_W + SAMPLE_W;
    localparam int ACC_W  = PROD_W + 4;

    typedef logic signed [SAMPLE_W-1:0]   sample_t;
    typedef logic signed [COEF_W-1:0]     coef_t;
    typedef logic        [CH_FIELD_W-1:0] chan_t;

    // Register indexes of the configuration port.
    typedef enum logic [2:0] {
        IDX_B0 = 3'd0,
        IDX_B1 = 3'd1,
        IDX_B2 = 3'd2,
        IDX_B3 = 3'd3,
        IDX_A1 = 3'd4,
        IDX_A2 = 3'd5,
        IDX_A3 = 3'd6
    } coef_idx_t;

    typedef coef_t coef_set_t [NUM_COEFS];

    // 3rd-order Butterworth low-pass, Fs = 500 Hz, Fc = 20 Hz, Q4.24.
    localparam coef_t COEF_RESET [NUM_COEFS] = '{
        28'sd26290, 28'sd78870, 28'sd78870, 28'sd26290,
        -28'sd41919692, 28'sd35488076, -28'sd10135279
    };

    typedef struct packed {
        sample_t sample;
        chan_t   channel;
    } in_item_t;

    typedef struct packed {
        sample_t filtered;
        chan_t   out_channel;
    } out_item_t;

    // Per-channel filter history: three past inputs and three past outputs.
    typedef struct packed {
        sample_t x1;
        sample_t x2;
        sample_t x3;
        sample_t y1;
        sample_t y2;
        sample_t y3;
    } hist_t;

endpackage

// ===== src/toiir_stream_if.sv =====
interface toiir_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/third_order_iir_multichannel.sv =====
// Third-order direct-form-I IIR filter over interleaved channels.
//
// samples (sink): one transaction carries a signed 24-bit sample and a 3-bit channel.
// results (source): one transaction per sample, the rounded and saturated filter
//   output and the channel it belongs to, in the order the samples came in.
// wr_en / wr_index / wr_data: write coefficient b0, b1, b2, b3, a1, a2, a3 at
//   index 0..6 (signed Q4.24); other indexes are dropped. Write only while idle.
//
// A sample goes from the compute stage to the result register. Throughput: one
//   sample per cycle unless results stall, any channel order, same channel back
//   to back included. The cycle is set by the seven parallel 28x24 multiplies and
//   their sum feeding the result register; a channel's history is written at that
//   same edge and forwarded to a following sample of the same channel.
// Reset: coefficients return to the 20 Hz Butterworth set, all history reads as
//   zero through per-channel valid bits, both handshakes go idle at once.
// A stalled receiver holds the result register; one more sample may wait in the
//   compute stage, after which samples.ready drops until results drain.
// A channel number at or beyond CHANNELS is filtered with zero history and
//   leaves all history untouched.
module third_order_iir_multichannel
    import toiir_pkg::*;
#(
    parameter int CHANNELS = DEFAULT_CHANNELS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    toiir_stream_if.sink            samples,
    toiir_stream_if.source          results,
    input  logic                    wr_en,
    input  logic [2:0]              wr_index,
    input  logic [COEF_W-1:0]       wr_data
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CMP_W = 8;

    // Coefficient registers.
    coef_set_t coef_reg;

    // Compute stage: one sample with its history.
    logic                  stg_valid_reg;
    sample_t               stg_sample_reg;
    chan_t                 stg_channel_reg;
    logic                  stg_chok_reg;
    logic [IDX_W-1:0]      stg_idx_reg;

    // History store, its registered read and the forwarding path.
    hist_t                 hist_mem [CHANNELS];
    logic [CHANNELS-1:0]   hvalid_reg;
    hist_t                 mem_rd_reg;
    logic                  hvok_reg;
    logic                  byp_reg;
    hist_t                 byp_hist_reg;

    // Result register.
    logic                  out_valid_reg;
    out_item_t             out_data_reg;

    logic                  stage_adv;
    logic                  accept;
    logic [CMP_W-1:0]      ch_wide;
    logic                  in_chok;
    logic [IDX_W-1:0]      in_idx;
    logic                  fwd;
    hist_t                 hist_cur;
    hist_t                 hist_new;
    sample_t               y;

    // Handshakes: the stage moves on whenever the result register is free or
    // being emptied; a new sample enters whenever the stage moves or is empty.
    assign stage_adv     = stg_valid_reg && (!out_valid_reg || results.ready);
    assign samples.ready = !stg_valid_reg || stage_adv;
    assign accept        = samples.valid && samples.ready;

    assign results.valid = out_valid_reg;
    assign results.data  = out_data_reg;

    // Decode the incoming channel.
    assign ch_wide = CMP_W'(samples.data.channel);
    assign in_chok = ch_wide < CMP_W'(CHANNELS);
    assign in_idx  = ch_wide[IDX_W-1:0];

    // Forward when the sample in the stage writes the channel being read now.
    assign fwd = stage_adv && stg_chok_reg && in_chok && (stg_idx_reg == in_idx);

    always_comb
    begin
        if (byp_reg)
        begin
            hist_cur = byp_hist_reg;
        end
        else if (hvok_reg)
        begin
            hist_cur = mem_rd_reg;
        end
        else
        begin
            hist_cur = '0;
        end
    end

    toiir_datapath u_datapath (
        .coefs    (coef_reg),
        .sample   (stg_sample_reg),
        .hist     (hist_cur),
        .filtered (y)
    );

    // Shift the new sample and result into the channel's history.
    always_comb
    begin
        hist_new.x1 = stg_sample_reg;
        hist_new.x2 = hist_cur.x1;
        hist_new.x3 = hist_cur.x2;
        hist_new.y1 = y;
        hist_new.y2 = hist_cur.y1;
        hist_new.y3 = hist_cur.y2;
    end

    // Coefficient writes; indexes past the last coefficient are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= COEF_RESET;
        end
        else if (wr_en && (wr_index <= IDX_A3))
        begin
            coef_reg[wr_index] <= coef_t'(wr_data);
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            hvalid_reg    <= '0;
            hvok_reg      <= 1'b0;
            byp_reg       <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                stg_valid_reg <= 1'b1;
                hvok_reg      <= in_chok && hvalid_reg[in_idx];
                byp_reg       <= fwd;
            end
            else if (stage_adv)
            begin
                stg_valid_reg <= 1'b0;
            end

            if (stage_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (stage_adv && stg_chok_reg)
            begin
                hvalid_reg[stg_idx_reg] <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stg_sample_reg  <= samples.data.sample;
            stg_channel_reg <= samples.data.channel;
            stg_chok_reg    <= in_chok;
            stg_idx_reg     <= in_idx;
            byp_hist_reg    <= hist_new;
        end
        if (stage_adv)
        begin
            out_data_reg.filtered    <= y;
            out_data_reg.out_channel <= stg_channel_reg;
        end
    end

    // History memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (stage_adv && stg_chok_reg)
        begin
            hist_mem[stg_idx_reg] <= hist_new;
        end
        if (accept)
        begin
            mem_rd_reg <= hist_mem[in_idx];
        end
    end

endmodule

// ===== src/toiir_datapath.sv =====
module toiir_datapath
    import toiir_pkg::*;
(
    input  coef_set_t coefs,
    input  sample_t   sample,
    input  hist_t     hist,
    output sample_t   filtered
);

    localparam int SHIFT_W = ACC_W - FRAC_W;
    localparam logic signed [ACC_W-1:0]   ROUND_HALF = ACC_W'(1) <<< (FRAC_W - 1);
    localparam logic signed [SHIFT_W-1:0] OUT_MAX    = SHIFT_W'((1 <<< (SAMPLE_W - 1)) - 1);
    localparam logic signed [SHIFT_W-1:0] OUT_MIN    = -(SHIFT_W'(1) <<< (SAMPLE_W - 1));

    sample_t                    operand [NUM_COEFS];
    logic signed [PROD_W-1:0]   prod    [NUM_COEFS];
    logic signed [ACC_W-1:0]    acc;
    logic signed [ACC_W-1:0]    rounded;
    logic signed [SHIFT_W-1:0]  shifted;

    assign operand[IDX_B0] = sample;
    assign operand[IDX_B1] = hist.x1;
    assign operand[IDX_B2] = hist.x2;
    assign operand[IDX_B3] = hist.x3;
    assign operand[IDX_A1] = hist.y1;
    assign operand[IDX_A2] = hist.y2;
    assign operand[IDX_A3] = hist.y3;

    // Seven independent signed multiplies.
    always_comb
    begin
        for (int i = 0; i < NUM_COEFS; i++)
        begin
            prod[i] = PROD_W'(coefs[i]) * PROD_W'(operand[i]);
        end
    end

    // Feedforward terms add, feedback terms subtract.
    always_comb
    begin
        acc = ACC_W'(prod[IDX_B0]) + ACC_W'(prod[IDX_B1])
            + ACC_W'(prod[IDX_B2]) + ACC_W'(prod[IDX_B3])
            - ACC_W'(prod[IDX_A1]) - ACC_W'(prod[IDX_A2])
            - ACC_W'(prod[IDX_A3]);
    end

    // Round half up, drop the fraction, clamp to the sample range.
    assign rounded = acc + ROUND_HALF;
    assign shifted = SHIFT_W'(rounded >>> FRAC_W);

    always_comb
    begin
        if (shifted > OUT_MAX)
        begin
            filtered = SAMPLE_W'(OUT_MAX);
        end
        else if (shifted < OUT_MIN)
        begin
            filtered = SAMPLE_W'(OUT_MIN);
        end
        else
        begin
            filtered = SAMPLE_W'(shifted);
        end
    end

endmodule
